[sv/psd_pkg.sv]
// Shared widths and cell payload types for the point to segment distance pipeline.
// No dependencies.
package psd_pkg;

	localparam int CB    = 16;            // coordinate bits
	localparam int FB    = 8;             // fraction bits of results
	localparam int DW    = CB + 1;        // coordinate difference
	localparam int PRW   = 2 * DW;        // product of two differences
	localparam int DOTW  = PRW + 1;       // dot product
	localparam int L2W   = 2 * CB + 1;    // squared length
	localparam int QW    = CB + FB;       // quotient bits of the offset
	localparam int MW    = L2W + QW;      // dividend of the offset
	localparam int PTW   = CB + FB;       // closest point, Q.FB
	localparam int EW    = CB + FB;       // magnitude of point error
	localparam int SW    = 2 * EW + 1;    // sum of squared errors
	localparam int DISTW = CB + FB + 1;   // distance
	localparam int SPW   = 2 * DISTW;     // radicand, padded to whole digit pairs
	localparam int RW    = DISTW + 3;     // root remainder

	typedef struct packed {
		logic [L2W-1:0]        rem_x;
		logic [QW-1:0]         lo_x;
		logic [L2W-1:0]        rem_y;
		logic [QW-1:0]         lo_y;
		logic [L2W-1:0]        len2;
		logic                  neg_x;
		logic                  neg_y;
		logic                  zero_len;
		logic                  on;
		logic                  only;
		logic signed [CB-1:0]  ax;
		logic signed [CB-1:0]  ay;
		logic signed [CB-1:0]  cx;
		logic signed [CB-1:0]  cy;
	} div_t;

	typedef struct packed {
		logic [RW-1:0]         rem;
		logic [DISTW-1:0]      root;
		logic [SPW-1:0]        rad;
		logic signed [PTW-1:0] qx;
		logic signed [PTW-1:0] qy;
		logic                  on;
		logic                  nores;
	} sq_t;

endpackage

[sv/psd_div_cell.sv]
// One restoring division step for both axes: one quotient bit each.
// Depends on psd_pkg.
module psd_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  psd_pkg::div_t in_data,
	output logic          out_valid,
	output psd_pkg::div_t out_data
);
	import psd_pkg::*;

	logic [L2W:0] tx, ty;
	logic         gx, gy;
	div_t         nxt;

	always_comb begin
		tx = {in_data.rem_x, in_data.lo_x[QW-1]};
		ty = {in_data.rem_y, in_data.lo_y[QW-1]};
		gx = tx >= {1'b0, in_data.len2};
		gy = ty >= {1'b0, in_data.len2};
		nxt = in_data;
		nxt.rem_x = gx ? L2W'(tx - {1'b0, in_data.len2}) : tx[L2W-1:0];
		nxt.rem_y = gy ? L2W'(ty - {1'b0, in_data.len2}) : ty[L2W-1:0];
		nxt.lo_x = {in_data.lo_x[QW-2:0], gx};
		nxt.lo_y = {in_data.lo_y[QW-2:0], gy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end
endmodule

[sv/psd_sqrt_cell.sv]
// One digit step of the restoring square root: one root bit.
// Depends on psd_pkg.
module psd_sqrt_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  psd_pkg::sq_t in_data,
	output logic         out_valid,
	output psd_pkg::sq_t out_data
);
	import psd_pkg::*;

	logic [RW-1:0] t, trial;
	logic          g;
	sq_t           nxt;

	always_comb begin
		t = {in_data.rem[RW-3:0], in_data.rad[SPW-1:SPW-2]};
		trial = {1'b0, in_data.root, 2'b01};
		g = t >= trial;
		nxt = in_data;
		nxt.rem = g ? t - trial : t;
		nxt.root = {in_data.root[DISTW-2:0], g};
		nxt.rad = {in_data.rad[SPW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end
endmodule

[sv/point_segment_distance.sv]
// Point to segment distance: closest point on segment A..B to P and its distance.
// Registers in order: s1..s5, the 24-cell division row, s6..s10, the 25-cell
// square root row and the output register; one query per cycle.
// busy is always low; done pulses one cycle with the result, no stall.
// Asynchronous active-low reset clears all valid flags; payload is not reset.
// Depends on psd_pkg, psd_div_cell, psd_sqrt_cell.
module point_segment_distance (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [psd_pkg::CB-1:0]    point_x,
	input  logic signed [psd_pkg::CB-1:0]    point_y,
	input  logic signed [psd_pkg::CB-1:0]    start_x,
	input  logic signed [psd_pkg::CB-1:0]    start_y,
	input  logic signed [psd_pkg::CB-1:0]    end_x,
	input  logic signed [psd_pkg::CB-1:0]    end_y,
	input  logic                             only_on_segment,
	output logic                             done,
	output logic [psd_pkg::DISTW-1:0]        distance,
	output logic signed [psd_pkg::PTW-1:0]   closest_x,
	output logic signed [psd_pkg::PTW-1:0]   closest_y,
	output logic                             on_segment,
	output logic                             no_result
);
	import psd_pkg::*;

	// every stage advances each cycle; nothing ever holds the input off
	assign busy = 1'b0;

	// s1: differences against segment start
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, px_s1, py_s1;
	logic signed [CB-1:0] ax_s1, ay_s1, cx_s1, cy_s1;
	logic                 only_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DW'(end_x) - DW'(start_x);
		dy_s1 <= DW'(end_y) - DW'(start_y);
		px_s1 <= DW'(point_x) - DW'(start_x);
		py_s1 <= DW'(point_y) - DW'(start_y);
		ax_s1 <= start_x;
		ay_s1 <= start_y;
		cx_s1 <= point_x;
		cy_s1 <= point_y;
		only_s1 <= only_on_segment;
	end

	// s2: the four products, plus direction magnitudes and signs
	logic                  v_s2;
	logic signed [PRW-1:0] pdx_s2, pdy_s2, ddx_s2, ddy_s2;
	logic [CB-1:0]         magx_s2, magy_s2;
	logic                  negx_s2, negy_s2;
	logic signed [CB-1:0]  ax_s2, ay_s2, cx_s2, cy_s2;
	logic                  only_s2;
	logic signed [DW-1:0]  ndx, ndy;

	assign ndx = -dx_s1;
	assign ndy = -dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pdx_s2 <= px_s1 * dx_s1;
		pdy_s2 <= py_s1 * dy_s1;
		ddx_s2 <= dx_s1 * dx_s1;
		ddy_s2 <= dy_s1 * dy_s1;
		magx_s2 <= dx_s1[DW-1] ? ndx[CB-1:0] : dx_s1[CB-1:0];
		magy_s2 <= dy_s1[DW-1] ? ndy[CB-1:0] : dy_s1[CB-1:0];
		negx_s2 <= dx_s1[DW-1];
		negy_s2 <= dy_s1[DW-1];
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
		only_s2 <= only_s1;
	end

	// s3: dot product and squared length
	logic                   v_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic [L2W-1:0]         len2_s3;
	logic [DOTW-1:0]        len2_sum;
	logic [CB-1:0]          magx_s3, magy_s3;
	logic                   negx_s3, negy_s3;
	logic signed [CB-1:0]   ax_s3, ay_s3, cx_s3, cy_s3;
	logic                   only_s3;

	assign len2_sum = DOTW'(ddx_s2) + DOTW'(ddy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dot_s3 <= DOTW'(pdx_s2) + DOTW'(pdy_s2);
		len2_s3 <= len2_sum[L2W-1:0];
		magx_s3 <= magx_s2;
		magy_s3 <= magy_s2;
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		cx_s3 <= cx_s2;
		cy_s3 <= cy_s2;
		only_s3 <= only_s2;
	end

	// s4: clamp the dot product to 0..len2; zero-length segment counts as on
	logic                 v_s4;
	logic [L2W-1:0]       dotc_s4, len2_s4;
	logic                 on_s4, zl_s4;
	logic [CB-1:0]        magx_s4, magy_s4;
	logic                 negx_s4, negy_s4;
	logic signed [CB-1:0] ax_s4, ay_s4, cx_s4, cy_s4;
	logic                 only_s4;
	logic [L2W-1:0]       dotc_c;
	logic                 on_c, zl_c;

	always_comb begin
		zl_c = len2_s3 == '0;
		if (zl_c) begin
			dotc_c = '0;
			on_c = 1'b1;
		end else if (dot_s3[DOTW-1]) begin
			dotc_c = '0;
			on_c = 1'b0;
		end else if (dot_s3 > $signed({2'b00, len2_s3})) begin
			dotc_c = len2_s3;
			on_c = 1'b0;
		end else begin
			dotc_c = dot_s3[L2W-1:0];
			on_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dotc_s4 <= dotc_c;
		len2_s4 <= len2_s3;
		on_s4 <= on_c;
		zl_s4 <= zl_c;
		magx_s4 <= magx_s3;
		magy_s4 <= magy_s3;
		negx_s4 <= negx_s3;
		negy_s4 <= negy_s3;
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;
		cx_s4 <= cx_s3;
		cy_s4 <= cy_s3;
		only_s4 <= only_s3;
	end

	// s5: offset dividends dotc*|d|*2^FB, loaded into the division row
	logic              v_s5;
	div_t              div_s5;
	logic [MW-1:0]     mx, my;

	// product is full width (L2W+CB bits) before the fraction shift
	assign mx = {(L2W+CB)'(dotc_s4) * (L2W+CB)'(magx_s4), {FB{1'b0}}};
	assign my = {(L2W+CB)'(dotc_s4) * (L2W+CB)'(magy_s4), {FB{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		div_s5.rem_x <= mx[MW-1:QW];
		div_s5.lo_x <= mx[QW-1:0];
		div_s5.rem_y <= my[MW-1:QW];
		div_s5.lo_y <= my[QW-1:0];
		div_s5.len2 <= len2_s4;
		div_s5.neg_x <= negx_s4;
		div_s5.neg_y <= negy_s4;
		div_s5.zero_len <= zl_s4;
		div_s5.on <= on_s4;
		div_s5.only <= only_s4;
		div_s5.ax <= ax_s4;
		div_s5.ay <= ay_s4;
		div_s5.cx <= cx_s4;
		div_s5.cy <= cy_s4;
	end

	// division row: one quotient bit per cell; the quotient is below 2^QW
	logic [QW:0] dv;
	div_t        dd [QW+1];

	assign dv[0] = v_s5;
	assign dd[0] = div_s5;

	for (genvar i = 0; i < QW; i++) begin : g_div
		psd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv[i]),
			.in_data  (dd[i]),
			.out_valid(dv[i+1]),
			.out_data (dd[i+1])
		);
	end

	// s6: round to nearest, ties away from zero (2*rem >= len2)
	div_t                 dq;
	logic                 v_s6;
	logic [QW:0]          offx_s6, offy_s6;
	logic                 negx_s6, negy_s6, on_s6, only_s6;
	logic signed [CB-1:0] ax_s6, ay_s6, cx_s6, cy_s6;
	logic                 rux, ruy;

	assign dq = dd[QW];
	assign rux = {dq.rem_x, 1'b0} >= {1'b0, dq.len2};
	assign ruy = {dq.rem_y, 1'b0} >= {1'b0, dq.len2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= dv[QW];
		end
	end

	always_ff @(posedge clk) begin
		offx_s6 <= dq.zero_len ? '0 : {1'b0, dq.lo_x} + (QW+1)'(rux);
		offy_s6 <= dq.zero_len ? '0 : {1'b0, dq.lo_y} + (QW+1)'(ruy);
		negx_s6 <= dq.neg_x;
		negy_s6 <= dq.neg_y;
		on_s6 <= dq.on;
		only_s6 <= dq.only;
		ax_s6 <= dq.ax;
		ay_s6 <= dq.ay;
		cx_s6 <= dq.cx;
		cy_s6 <= dq.cy;
	end

	// s7: closest point = A*2^FB +/- offset
	logic                  v_s7;
	logic signed [PTW-1:0] qx_s7, qy_s7;
	logic signed [CB-1:0]  cx_s7, cy_s7;
	logic                  on_s7, only_s7;
	logic signed [PTW+1:0] bx, by, ox, oy, sx, sy;

	always_comb begin
		bx = (PTW+2)'($signed({ax_s6, {FB{1'b0}}}));
		by = (PTW+2)'($signed({ay_s6, {FB{1'b0}}}));
		ox = $signed({1'b0, offx_s6});
		oy = $signed({1'b0, offy_s6});
		sx = negx_s6 ? bx - ox : bx + ox;
		sy = negy_s6 ? by - oy : by + oy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		qx_s7 <= sx[PTW-1:0];
		qy_s7 <= sy[PTW-1:0];
		cx_s7 <= cx_s6;
		cy_s7 <= cy_s6;
		on_s7 <= on_s6;
		only_s7 <= only_s6;
	end

	// s8: error magnitudes in Q.FB
	logic                  v_s8;
	logic [EW-1:0]         ex_s8, ey_s8;
	logic signed [PTW-1:0] qx_s8, qy_s8;
	logic                  on_s8, only_s8;
	logic signed [PTW:0]   erx, ery, nerx, nery;

	always_comb begin
		erx = (PTW+1)'($signed({cx_s7, {FB{1'b0}}})) - (PTW+1)'(qx_s7);
		ery = (PTW+1)'($signed({cy_s7, {FB{1'b0}}})) - (PTW+1)'(qy_s7);
		nerx = -erx;
		nery = -ery;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		ex_s8 <= erx[PTW] ? nerx[EW-1:0] : erx[EW-1:0];
		ey_s8 <= ery[PTW] ? nery[EW-1:0] : ery[EW-1:0];
		qx_s8 <= qx_s7;
		qy_s8 <= qy_s7;
		on_s8 <= on_s7;
		only_s8 <= only_s7;
	end

	// s9: squares
	logic                  v_s9;
	logic [2*EW-1:0]       sqx_s9, sqy_s9;
	logic signed [PTW-1:0] qx_s9, qy_s9;
	logic                  on_s9, only_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s9 <= ex_s8 * ex_s8;
		sqy_s9 <= ey_s8 * ey_s8;
		qx_s9 <= qx_s8;
		qy_s9 <= qy_s8;
		on_s9 <= on_s8;
		only_s9 <= only_s8;
	end

	// s10: radicand, loaded into the square root row
	logic          v_s10;
	sq_t           sq_s10;
	logic [SW-1:0] ssum;

	assign ssum = SW'(sqx_s9) + SW'(sqy_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		sq_s10.rem <= '0;
		sq_s10.root <= '0;
		sq_s10.rad <= SPW'(ssum);
		sq_s10.qx <= qx_s9;
		sq_s10.qy <= qy_s9;
		sq_s10.on <= on_s9;
		sq_s10.nores <= only_s9 & ~on_s9;
	end

	// square root row: one root bit per cell
	logic [DISTW:0] sv;
	sq_t            sd [DISTW+1];

	assign sv[0] = v_s10;
	assign sd[0] = sq_s10;

	for (genvar j = 0; j < DISTW; j++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sv[j]),
			.in_data  (sd[j]),
			.out_valid(sv[j+1]),
			.out_data (sd[j+1])
		);
	end

	// output register: round the root to nearest, zero it when there is no result
	sq_t sf;
	assign sf = sd[DISTW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sv[DISTW];
		end
	end

	always_ff @(posedge clk) begin
		distance <= sf.nores ? '0
			: sf.root + DISTW'(sf.rem > RW'(sf.root));
		closest_x <= sf.qx;
		closest_y <= sf.qy;
		on_segment <= sf.on;
		no_result <= sf.nores;
	end
endmodule
